// File: rtl/core/ogru_pkg.sv
package ogru_pkg;

    // field widths
    localparam int FUNC_W      = 2;
    localparam int COORD_W     = 12;
    localparam int CFG_COORD_W = 10;
    localparam int CFG_DIM_W   = 11;
    localparam int CELL_W      = 8;
    localparam int COUNT_W     = 13;
    localparam int CFG_IDX_W   = 2;
    // grid limit: holds up to the largest grid side (4096)
    localparam int LIM_W       = 13;
    // Bresenham error term
    localparam int ERR_W       = 15;

    localparam int GRID_SIDE_DEF = 1024;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;

    // configuration reset values
    localparam logic [CFG_COORD_W-1:0] RST_ORIGIN_X = 10'd50;
    localparam logic [CFG_COORD_W-1:0] RST_ORIGIN_Y = 10'd50;
    localparam logic [CFG_DIM_W-1:0]   RST_WIDTH    = 11'd100;
    localparam logic [CFG_DIM_W-1:0]   RST_HEIGHT   = 11'd100;

    // cell values
    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;
    localparam logic signed [CELL_W-1:0] CELL_EMPTY   = 8'sd0;
    localparam logic signed [CELL_W-1:0] OCC_MAX      = 8'sd100;
    localparam logic signed [CELL_W:0]   FREE_STEP    = 9'sd5;
    localparam logic signed [CELL_W:0]   HIT_STEP     = 9'sd10;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]   grid_height;
        logic [CFG_DIM_W-1:0]   grid_width;
        logic [CFG_COORD_W-1:0] ray_origin_y;
        logic [CFG_COORD_W-1:0] ray_origin_x;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
        logic [FUNC_W-1:0]  func;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] cells_updated;
        logic [CELL_W-1:0]  cell_value;
        logic               outcome;
    } t_result;

endpackage

// File: rtl/core/occupancy_grid_ray_update.sv
// Items are handled one at a time: a new item is taken only once the last
//   result has been handed to the output register.
// Throughput: one grid cell per cycle on a ray,
//   set by the single read-modify-write port pair of the grid store.
// Reset (synchronous, active low): config to defaults, then a clearing pass
//   that writes unknown to every grid cell, with s_axis_tready low.
module occupancy_grid_ray_update #(
    parameter int GRID_SIDE = ogru_pkg::GRID_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ogru_pkg::CFG_DIM_W-1:0]   i_cfg_data,
    // input items
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [23:0]                      i_s_axis_tdata,  // cell_x[11:0], cell_y[23:12]
    input  logic [ogru_pkg::FUNC_W-1:0]      i_s_axis_tuser,  // func[1:0]
    // results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [23:0]                      o_m_axis_tdata,  // cell_value[7:0], cells_updated[20:8], zero[23:21]
    output logic [0:0]                       o_m_axis_tuser   // outcome[0]
);

    localparam int MEM_AW = 2 * $clog2(GRID_SIDE);

    ogru_pkg::t_cfg    r_cfg;
    ogru_pkg::t_item   item;
    ogru_pkg::t_result seq_result;
    ogru_pkg::t_result r_m_result;
    logic              r_m_tvalid;

    logic                        s_accept;
    logic                        seq_idle;
    logic                        seq_done;
    logic                        out_free;
    logic                        mem_we;
    logic [MEM_AW-1:0]           mem_waddr;
    logic [ogru_pkg::CELL_W-1:0] mem_wdata;
    logic [MEM_AW-1:0]           mem_raddr;
    logic [ogru_pkg::CELL_W-1:0] mem_rdata;

    // Config registers: writes always taken, unknown index ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ray_origin_x <= ogru_pkg::RST_ORIGIN_X;
            r_cfg.ray_origin_y <= ogru_pkg::RST_ORIGIN_Y;
            r_cfg.grid_width   <= ogru_pkg::RST_WIDTH;
            r_cfg.grid_height  <= ogru_pkg::RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ogru_pkg::CFG_ORIGIN_X: r_cfg.ray_origin_x <= i_cfg_data[ogru_pkg::CFG_COORD_W-1:0];
                ogru_pkg::CFG_ORIGIN_Y: r_cfg.ray_origin_y <= i_cfg_data[ogru_pkg::CFG_COORD_W-1:0];
                ogru_pkg::CFG_WIDTH:    r_cfg.grid_width   <= i_cfg_data;
                ogru_pkg::CFG_HEIGHT:   r_cfg.grid_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input side: the sequencer takes one item at a time, only when idle.
    assign o_s_axis_tready = seq_idle;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        item.func   = i_s_axis_tuser;
        item.cell_x = i_s_axis_tdata[11:0];
        item.cell_y = i_s_axis_tdata[23:12];
    end

    // Output register decouples the result from the next item's work; the
    // sequencer only hands over a result when this slot is free or draining.
    assign out_free = !r_m_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (seq_done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_m_result <= seq_result;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {3'b000, r_m_result.cells_updated, r_m_result.cell_value};
    assign o_m_axis_tuser  = r_m_result.outcome;

    ogru_ray_seq #(
        .GRID_SIDE (GRID_SIDE),
        .MEM_AW    (MEM_AW)
    ) u_ray_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (s_accept),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .o_result    (seq_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ogru_grid_mem #(
        .ADDR_W (MEM_AW)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // a finished result never overwrites one still waiting
    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> (!r_m_tvalid || i_m_axis_tready)
    ) else $error("result loaded while output slot still held");

    // an accepted transaction makes the block busy on the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready
    ) else $error("input ready right after an accepted transaction");

    // an endpoint outside the grid always reads back as unknown
    a_outside_unknown: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[7:0] == 8'hFF)
    ) else $error("outside endpoint with known cell value");

endmodule

// File: rtl/core/ogru_grid_mem.sv
// Grid cell store: one write port, one read port, registered read data.
module ogru_grid_mem #(
    parameter int ADDR_W = 20
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [ogru_pkg::CELL_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [ogru_pkg::CELL_W-1:0] o_rdata
);

    logic [ogru_pkg::CELL_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [ogru_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ogru_cell_update.sv
// Evidence update of one cell: free clears toward 0, hit raises toward 100.
module ogru_cell_update (
    input  logic                               i_is_hit,
    input  logic signed [ogru_pkg::CELL_W-1:0] i_value,
    output logic signed [ogru_pkg::CELL_W-1:0] o_value
);

    logic signed [ogru_pkg::CELL_W:0] v_ext;
    logic signed [ogru_pkg::CELL_W:0] sum;
    logic signed [ogru_pkg::CELL_W:0] occ_max_ext;

    always_comb begin
        v_ext       = {i_value[ogru_pkg::CELL_W-1], i_value};
        occ_max_ext = {ogru_pkg::OCC_MAX[ogru_pkg::CELL_W-1], ogru_pkg::OCC_MAX};
        if (i_is_hit) begin
            sum = v_ext + ogru_pkg::HIT_STEP;
            if (i_value == ogru_pkg::CELL_UNKNOWN) begin
                o_value = ogru_pkg::OCC_MAX;
            end else if (sum > occ_max_ext) begin
                o_value = ogru_pkg::OCC_MAX;
            end else begin
                o_value = sum[ogru_pkg::CELL_W-1:0];
            end
        end else begin
            sum = v_ext - ogru_pkg::FREE_STEP;
            if (i_value == ogru_pkg::CELL_UNKNOWN) begin
                o_value = ogru_pkg::CELL_EMPTY;
            end else if (sum[ogru_pkg::CELL_W]) begin
                o_value = ogru_pkg::CELL_EMPTY;
            end else begin
                o_value = sum[ogru_pkg::CELL_W-1:0];
            end
        end
    end

endmodule

// File: rtl/core/ogru_ray_seq.sv
// Sequencer: clear pass, Bresenham stepper (one cell per cycle),
// read-modify-write pipeline into the grid store, endpoint readback.
module ogru_ray_seq #(
    parameter int GRID_SIDE = ogru_pkg::GRID_SIDE_DEF,
    parameter int MEM_AW    = 2 * $clog2(GRID_SIDE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ogru_pkg::t_cfg              i_cfg,
    input  logic                        i_start,
    input  ogru_pkg::t_item             i_item,
    input  logic                        i_out_free,
    output logic                        o_idle,
    output logic                        o_done,
    output ogru_pkg::t_result           o_result,
    output logic                        o_mem_we,
    output logic [MEM_AW-1:0]           o_mem_waddr,
    output logic [ogru_pkg::CELL_W-1:0] o_mem_wdata,
    output logic [MEM_AW-1:0]           o_mem_raddr,
    input  logic [ogru_pkg::CELL_W-1:0] i_mem_rdata
);

    localparam int CW    = ogru_pkg::COORD_W;
    localparam int EW    = ogru_pkg::ERR_W;
    localparam int LW    = ogru_pkg::LIM_W;
    localparam int AW    = MEM_AW / 2;
    localparam logic [LW-1:0] SIDE_LIM = LW'(GRID_SIDE);
    localparam logic signed [CW-1:0] COORD_ONE = CW'(1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DELTA   = 3'd2;
    localparam logic [2:0] S_SETUP   = 3'd3;
    localparam logic [2:0] S_WALK    = 3'd4;
    localparam logic [2:0] S_FLUSH   = 3'd5;
    localparam logic [2:0] S_END_RD  = 3'd6;
    localparam logic [2:0] S_END_CAP = 3'd7;

    function automatic logic f_in_grid(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic [LW-1:0] wl,
                                       input logic [LW-1:0] hl);
        return !x[CW-1] && !y[CW-1] && ({1'b0, x} < wl) && ({1'b0, y} < hl);
    endfunction

    logic [2:0]                     r_state, n_state;
    logic [MEM_AW-1:0]              r_clr_addr;
    logic                           r_pend_v;
    logic [MEM_AW-1:0]              r_pend_addr;
    logic [ogru_pkg::FUNC_W-1:0]    r_func;
    logic signed [CW-1:0]           r_ex, r_ey;
    logic [CW-1:0]                  r_adx, r_ady;
    logic                           r_xmajor;
    logic signed [CW-1:0]           r_a, r_b, r_aend;
    logic                           r_dirb_pos;
    logic signed [EW-1:0]           r_d, r_inc1, r_inc2;
    logic [ogru_pkg::COUNT_W-1:0]   r_count;

    logic [LW-1:0]                  wlim, hlim;
    logic signed [CW-1:0]           ox, oy;
    logic signed [CW:0]             ddx, ddy, neg_dx, neg_dy;
    logic [CW-1:0]                  adx, ady;
    logic                           xmaj;
    logic [CW-1:0]                  major, minor;
    logic signed [EW-1:0]           twice_minor, twice_major;
    logic signed [CW-1:0]           sa0, sb0, sa1, sb1;
    logic                           swap;
    logic signed [CW-1:0]           cur_x, cur_y;
    logic                           cur_in, end_in;
    logic [MEM_AW-1:0]              cur_addr, end_addr;
    logic signed [ogru_pkg::CELL_W-1:0] upd_value;

    // grid limits, clamped to the store's side
    always_comb begin
        wlim = ({2'b00, i_cfg.grid_width} > SIDE_LIM) ? SIDE_LIM : {2'b00, i_cfg.grid_width};
        hlim = ({2'b00, i_cfg.grid_height} > SIDE_LIM) ? SIDE_LIM : {2'b00, i_cfg.grid_height};
        ox   = $signed({2'b00, i_cfg.ray_origin_x});
        oy   = $signed({2'b00, i_cfg.ray_origin_y});
    end

    // delta stage: absolute offsets
    always_comb begin
        ddx    = {r_ex[CW-1], r_ex} - {ox[CW-1], ox};
        ddy    = {r_ey[CW-1], r_ey} - {oy[CW-1], oy};
        neg_dx = -ddx;
        neg_dy = -ddy;
        adx    = ddx[CW] ? neg_dx[CW-1:0] : ddx[CW-1:0];
        ady    = ddy[CW] ? neg_dy[CW-1:0] : ddy[CW-1:0];
    end

    // setup stage: major axis, start end, error terms
    always_comb begin
        xmaj        = (r_ady <= r_adx);
        major       = xmaj ? r_adx : r_ady;
        minor       = xmaj ? r_ady : r_adx;
        twice_minor = $signed({2'b00, minor, 1'b0});
        twice_major = $signed({2'b00, major, 1'b0});
        sa0         = xmaj ? ox : oy;
        sb0         = xmaj ? oy : ox;
        sa1         = xmaj ? r_ex : r_ey;
        sb1         = xmaj ? r_ey : r_ex;
        swap        = (sa0 > sa1);
    end

    // current walk cell and endpoint
    always_comb begin
        cur_x    = r_xmajor ? r_a : r_b;
        cur_y    = r_xmajor ? r_b : r_a;
        cur_in   = f_in_grid(cur_x, cur_y, wlim, hlim);
        end_in   = f_in_grid(r_ex, r_ey, wlim, hlim);
        cur_addr = {cur_y[AW-1:0], cur_x[AW-1:0]};
        end_addr = {r_ey[AW-1:0], r_ex[AW-1:0]};
    end

    ogru_cell_update u_cell_update (
        .i_is_hit (r_func == ogru_pkg::FUNC_HIT),
        .i_value  ($signed(i_mem_rdata)),
        .o_value  (upd_value)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DELTA;
            end
            S_DELTA: n_state = S_SETUP;
            S_SETUP: begin
                case (r_func)
                    ogru_pkg::FUNC_FREE: n_state = S_WALK;
                    ogru_pkg::FUNC_HIT:  n_state = S_WALK;
                    ogru_pkg::FUNC_READ: n_state = S_END_RD;
                    default:             n_state = S_END_RD;
                endcase
            end
            S_WALK: begin
                if (r_a == r_aend) n_state = S_FLUSH;
            end
            S_FLUSH:  n_state = S_END_RD;
            S_END_RD: n_state = S_END_CAP;
            S_END_CAP: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pend_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= (r_state == S_WALK) && cur_in;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_func <= i_item.func;
                    r_ex   <= $signed(i_item.cell_x);
                    r_ey   <= $signed(i_item.cell_y);
                end
            end
            S_DELTA: begin
                r_adx <= adx;
                r_ady <= ady;
            end
            S_SETUP: begin
                r_count <= '0;
                r_d     <= twice_minor - $signed({3'b000, major});
                r_inc1  <= twice_minor;
                r_inc2  <= twice_minor - twice_major;
                if (r_func == ogru_pkg::FUNC_HIT) begin
                    // single cell at the endpoint
                    r_xmajor <= 1'b1;
                    r_a      <= r_ex;
                    r_b      <= r_ey;
                    r_aend   <= r_ex;
                end else begin
                    r_xmajor   <= xmaj;
                    r_a        <= swap ? sa1 : sa0;
                    r_b        <= swap ? sb1 : sb0;
                    r_aend     <= swap ? sa0 : sa1;
                    r_dirb_pos <= swap ? (sb0 > sb1) : (sb1 > sb0);
                end
            end
            S_WALK: begin
                r_pend_addr <= cur_addr;
                if (cur_in) begin
                    r_count <= r_count + 1'b1;
                end
                if (r_a != r_aend) begin
                    r_a <= r_a + COORD_ONE;
                    if (r_d[EW-1]) begin
                        r_d <= r_d + r_inc1;
                    end else begin
                        r_b <= r_dirb_pos ? r_b + COORD_ONE : r_b - COORD_ONE;
                        r_d <= r_d + r_inc2;
                    end
                end
            end
            default: ;
        endcase
    end

    // write port: clear pass, else the pending read-modify-write
    assign o_mem_we    = (r_state == S_CLEAR) || r_pend_v;
    assign o_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pend_addr;
    assign o_mem_wdata = (r_state == S_CLEAR) ? ogru_pkg::CELL_UNKNOWN : upd_value;
    assign o_mem_raddr = (r_state == S_WALK) ? cur_addr : end_addr;

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_END_CAP) && i_out_free;

    always_comb begin
        o_result.outcome       = !end_in;
        o_result.cell_value    = end_in ? i_mem_rdata : ogru_pkg::CELL_UNKNOWN;
        o_result.cells_updated = r_count;
    end

endmodule
